// ===== hw/rtl/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg
// Types, constants and helper functions shared by the straight dock controller.
// ----------------------------------------------------------------------------
package sdc_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_MULTIPLY,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       rot_en;
      logic [3:0] rot_idx;
      logic       mul_en;
      logic [2:0] mul_idx;
      logic       commit;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic out_busy;
   } stat_type;

   localparam logic [2:0] STS_MOVING   = 3'd0;
   localparam logic [2:0] STS_ARRIVED  = 3'd1;
   localparam logic [2:0] STS_OFFTRACK = 3'd2;
   localparam logic [2:0] STS_STALLED  = 3'd3;
   localparam logic [2:0] STS_TIMEOUT  = 3'd4;
   localparam logic [2:0] STS_ABORT    = 3'd5;
   localparam logic [2:0] STS_IDLE     = 3'd6;

   localparam logic [2:0] CSR_GOAL_TOL      = 3'd0;
   localparam logic [2:0] CSR_FINAL_YAW_TOL = 3'd1;
   localparam logic [2:0] CSR_LAT_TOL       = 3'd2;
   localparam logic [2:0] CSR_YAW_TOL       = 3'd3;
   localparam logic [2:0] CSR_PROG_EPS      = 3'd4;
   localparam logic [2:0] CSR_MAX_SPEED     = 3'd5;
   localparam logic [2:0] CSR_TIMEOUT       = 3'd6;
   localparam logic [2:0] CSR_STALL         = 3'd7;

   localparam logic [2:0] MUL_C_DX  = 3'd0;
   localparam logic [2:0] MUL_S_DY  = 3'd1;
   localparam logic [2:0] MUL_C_DY  = 3'd2;
   localparam logic [2:0] MUL_S_DX  = 3'd3;
   localparam logic [2:0] MUL_DX_DX = 3'd4;
   localparam logic [2:0] MUL_DY_DY = 3'd5;
   localparam logic [2:0] MUL_GSQ   = 3'd6;

   localparam logic [3:0] ROT_LAST = 4'd15;

   localparam logic signed [20:0] PI_Q16      = 21'sd205887;
   localparam logic signed [20:0] NEG_PI_Q16  = -21'sd205887;
   localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
   localparam logic signed [20:0] NEG_HALF_PI = -21'sd102944;
   localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;
   localparam logic signed [32:0] CORDIC_K    = 33'sd652032874;
   localparam logic [31:0]        MIN_SPEED   = 32'd1311;

   function automatic logic [15:0] atan_q16(input logic [3:0] i);
      logic [15:0] r;
      case (i)
         4'd0:  r = 16'd51472;
         4'd1:  r = 16'd30386;
         4'd2:  r = 16'd16055;
         4'd3:  r = 16'd8150;
         4'd4:  r = 16'd4091;
         4'd5:  r = 16'd2047;
         4'd6:  r = 16'd1024;
         4'd7:  r = 16'd512;
         4'd8:  r = 16'd256;
         4'd9:  r = 16'd128;
         4'd10: r = 16'd64;
         4'd11: r = 16'd32;
         4'd12: r = 16'd16;
         4'd13: r = 16'd8;
         4'd14: r = 16'd4;
         4'd15: r = 16'd2;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [20:0] wrap_angle(input logic signed [20:0] a);
      logic signed [20:0] r;
      r = a;
      if (r > PI_Q16) r = r - TWO_PI_Q16;
      if (r > PI_Q16) r = r - TWO_PI_Q16;
      if (r < NEG_PI_Q16) r = r + TWO_PI_Q16;
      if (r < NEG_PI_Q16) r = r + TWO_PI_Q16;
      return r;
   endfunction

endpackage

// ===== hw/rtl/sdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdc_ctrl
// Sequencer: rotation iterations, multiply steps, decision and output commit.
// ----------------------------------------------------------------------------
module sdc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sdc_pkg::stat_type stat,
   output sdc_pkg::cmd_type  cmd
);
   import sdc_pkg::*;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cmd         = '0;
      cmd.rot_idx = cnt_ff;
      cmd.mul_idx = cnt_ff[2:0];
      req_stall   = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = stat.skip ? ST_DECIDE : ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            cmd.rot_en = 1'b1;
            cnt_in     = cnt_ff + 4'd1;
            if (cnt_ff == ROT_LAST) begin
               cnt_in   = '0;
               state_in = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            cmd.mul_en = 1'b1;
            cnt_in     = cnt_ff + 4'd1;
            if (cnt_ff[2:0] == MUL_GSQ) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/sdc_datapath.sv =====
// ----------------------------------------------------------------------------
// sdc_datapath
// Error rotation (cordic, shared multiplier), docking decision and state.
// ----------------------------------------------------------------------------
module sdc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_func,
   input  logic signed [31:0]  req_target_x,
   input  logic signed [31:0]  req_target_y,
   input  logic signed [18:0]  req_target_yaw,
   input  logic signed [31:0]  req_pose_x,
   input  logic signed [31:0]  req_pose_y,
   input  logic signed [18:0]  req_pose_yaw,
   input  logic                req_pose_valid,
   input  logic                req_stop_request,
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [19:0]         csr_wdata,
   input  sdc_pkg::cmd_type    cmd,
   output sdc_pkg::stat_type   stat,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic signed [20:0]  rsp_speed_x,
   output logic                rsp_done_res
);
   import sdc_pkg::*;

   // configuration
   logic [19:0] goal_tol_ff, lat_tol_ff, max_speed_ff;
   logic [17:0] fyaw_tol_ff, yaw_tol_ff;
   logic [15:0] eps_ff, timeout_ff, stall_lim_ff;

   // docking state
   logic               active_ff, active_in;
   logic signed [31:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic signed [18:0] goal_yaw_ff, goal_yaw_in;
   logic [31:0]        best_ff, best_in;
   logic [15:0]        stall_ff, stall_in, elapsed_ff, elapsed_in;

   // item staging
   logic               func_ff, valid_ff, stop_ff, neg_ff;
   logic signed [31:0] tx_ff, ty_ff;
   logic signed [18:0] tyaw_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic [17:0]        yerr_ff;

   // rotation and products
   logic signed [32:0] x_ff, y_ff;
   logic signed [19:0] z_ff;
   logic signed [54:0] prod_ff, lon_acc_ff, lat_acc_ff, dist_ff;
   logic               pend_ff;
   logic [2:0]         pidx_ff;
   logic [39:0]        gsq_ff;

   logic               rsp_valid_ff, rsp_done_ff;
   logic [2:0]         rsp_status_ff;
   logic signed [20:0] rsp_speed_ff;

   // ---------------- accept-time logic
   logic signed [31:0] goal_sel_x, goal_sel_y;
   logic signed [32:0] dx_new, dy_new;
   logic signed [20:0] yaw_w, z_fold, ydiff_w;
   logic               neg_new;
   logic [20:0]        yabs;

   always_comb begin
      goal_sel_x = req_func ? goal_x_ff : req_target_x;
      goal_sel_y = req_func ? goal_y_ff : req_target_y;
      dx_new     = 33'(goal_sel_x) - 33'(req_pose_x);
      dy_new     = 33'(goal_sel_y) - 33'(req_pose_y);
      yaw_w      = wrap_angle(21'(req_pose_yaw));
      z_fold     = yaw_w;
      neg_new    = 1'b0;
      if (yaw_w > HALF_PI_Q16) begin
         z_fold  = yaw_w - PI_Q16;
         neg_new = 1'b1;
      end else if (yaw_w < NEG_HALF_PI) begin
         z_fold  = yaw_w + PI_Q16;
         neg_new = 1'b1;
      end
      ydiff_w = wrap_angle(21'(goal_yaw_ff) - 21'(req_pose_yaw));
      yabs    = ydiff_w[20] ? 21'(-ydiff_w) : ydiff_w;
      stat.skip = req_func ?
                  (!active_ff || (elapsed_ff >= timeout_ff) || req_stop_request ||
                   !req_pose_valid) :
                  (req_stop_request || !req_pose_valid);
      stat.out_busy = rsp_valid_ff && rsp_stall;
   end

   // ---------------- cordic step
   logic signed [32:0] xs, ys;
   logic signed [19:0] atan_s;

   assign xs     = x_ff >>> cmd.rot_idx;
   assign ys     = y_ff >>> cmd.rot_idx;
   assign atan_s = 20'(atan_q16(cmd.rot_idx));

   // ---------------- shared multiplier
   logic signed [32:0] x_fin, y_fin;
   logic signed [20:0] c_op, s_op, mul_a;
   logic signed [33:0] mul_b;
   logic signed [54:0] prod_in;

   always_comb begin
      x_fin = neg_ff ? -x_ff : x_ff;
      y_fin = neg_ff ? -y_ff : y_ff;
      c_op  = 21'(x_fin >>> 14);
      s_op  = 21'(y_fin >>> 14);
      case (cmd.mul_idx)
         MUL_C_DX: begin mul_a = c_op;       mul_b = 34'(dx_ff); end
         MUL_S_DY: begin mul_a = s_op;       mul_b = 34'(dy_ff); end
         MUL_C_DY: begin mul_a = c_op;       mul_b = 34'(dy_ff); end
         MUL_S_DX: begin mul_a = s_op;       mul_b = 34'(dx_ff); end
         MUL_DX_DX: begin mul_a = dx_ff[20:0]; mul_b = 34'(dx_ff); end
         MUL_DY_DY: begin mul_a = dy_ff[20:0]; mul_b = 34'(dy_ff); end
         MUL_GSQ: begin
            mul_a = $signed({1'b0, goal_tol_ff});
            mul_b = $signed({14'b0, goal_tol_ff});
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      prod_in = 55'(mul_a) * 55'(mul_b);
   end

   // ---------------- decision
   logic signed [38:0] lon, lat;
   logic [38:0]        abs_lon, abs_lat;
   logic [32:0]        abs_dx, abs_dy;
   logic [31:0]        cur, mag1;
   logic [19:0]        mag;
   logic signed [33:0] best_lim;
   logic               arrive, off_track, progress, stalled;
   logic [15:0]        stall_inc;
   logic [2:0]         r_status;
   logic signed [20:0] r_speed;
   logic               r_done;

   always_comb begin
      lon     = lon_acc_ff[54:16];
      lat     = lat_acc_ff[54:16];
      abs_lon = lon[38] ? 39'(-lon) : 39'(lon);
      abs_lat = lat[38] ? 39'(-lat) : 39'(lat);
      abs_dx  = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
      abs_dy  = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
      cur     = (|abs_lon[38:32]) ? 32'hFFFF_FFFF : abs_lon[31:0];
      arrive  = (abs_dx <= 33'(goal_tol_ff)) && (abs_dy <= 33'(goal_tol_ff)) &&
                ($unsigned(dist_ff) <= 55'(gsq_ff)) && (yerr_ff <= fyaw_tol_ff);
      off_track = (abs_lat > 39'(lat_tol_ff)) || (yerr_ff > yaw_tol_ff);
      best_lim  = $signed({2'b0, best_ff}) - $signed({18'b0, eps_ff});
      progress  = $signed({2'b0, cur}) <= best_lim;
      stall_inc = (stall_ff == 16'hFFFF) ? stall_ff : stall_ff + 16'd1;
      stalled   = stall_inc > stall_lim_ff;
      mag1      = (cur > MIN_SPEED) ? cur : MIN_SPEED;
      mag       = (mag1 > 32'(max_speed_ff)) ? max_speed_ff : mag1[19:0];

      r_status    = STS_MOVING;
      r_speed     = '0;
      r_done      = 1'b0;
      active_in   = active_ff;
      goal_x_in   = goal_x_ff;
      goal_y_in   = goal_y_ff;
      goal_yaw_in = goal_yaw_ff;
      best_in     = best_ff;
      stall_in    = stall_ff;
      elapsed_in  = elapsed_ff;
      if (!func_ff) begin
         if (stop_ff || !valid_ff) begin
            r_status = STS_ABORT;
            r_done   = 1'b1;
         end else begin
            goal_x_in   = tx_ff;
            goal_y_in   = ty_ff;
            goal_yaw_in = tyaw_ff;
            best_in     = cur;
            stall_in    = '0;
            elapsed_in  = '0;
            active_in   = 1'b1;
         end
      end else if (!active_ff) begin
         r_status = STS_IDLE;
      end else if (elapsed_ff >= timeout_ff) begin
         r_status = STS_TIMEOUT;
         r_done   = 1'b1;
      end else begin
         elapsed_in = elapsed_ff + 16'd1;
         if (stop_ff || !valid_ff) begin
            r_status = STS_ABORT;
            r_done   = 1'b1;
         end else begin
            if (arrive) begin
               r_status = STS_ARRIVED;
               r_done   = 1'b1;
            end else if (off_track) begin
               r_status = STS_OFFTRACK;
               r_done   = 1'b1;
            end else if (progress) begin
               best_in  = cur;
               stall_in = '0;
            end else begin
               stall_in = stall_inc;
               if (stalled) begin
                  r_status = STS_STALLED;
                  r_done   = 1'b1;
               end
            end
            if (!r_done) begin
               r_speed = lon[38] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
         end
      end
      if (r_done) active_in = 1'b0;
   end

   // ---------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_tol_ff  <= 20'd1311;
         fyaw_tol_ff  <= 18'd2288;
         lat_tol_ff   <= 20'd3277;
         yaw_tol_ff   <= 18'd5719;
         eps_ff       <= 16'd131;
         max_speed_ff <= 20'd6554;
         timeout_ff   <= 16'd200;
         stall_lim_ff <= 16'd30;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GOAL_TOL:      goal_tol_ff  <= csr_wdata;
            CSR_FINAL_YAW_TOL: fyaw_tol_ff  <= csr_wdata[17:0];
            CSR_LAT_TOL:       lat_tol_ff   <= csr_wdata;
            CSR_YAW_TOL:       yaw_tol_ff   <= csr_wdata[17:0];
            CSR_PROG_EPS:      eps_ff       <= csr_wdata[15:0];
            CSR_MAX_SPEED:     max_speed_ff <= csr_wdata;
            CSR_TIMEOUT:       timeout_ff   <= csr_wdata[15:0];
            CSR_STALL:         stall_lim_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         goal_yaw_ff  <= '0;
         best_ff      <= '0;
         stall_ff     <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         pend_ff <= cmd.mul_en;
         if (cmd.commit) begin
            active_ff    <= active_in;
            goal_x_ff    <= goal_x_in;
            goal_y_ff    <= goal_y_in;
            goal_yaw_ff  <= goal_yaw_in;
            best_ff      <= best_in;
            stall_ff     <= stall_in;
            elapsed_ff   <= elapsed_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= req_func;
         valid_ff   <= req_pose_valid;
         stop_ff    <= req_stop_request;
         tx_ff      <= req_target_x;
         ty_ff      <= req_target_y;
         tyaw_ff    <= req_target_yaw;
         dx_ff      <= dx_new;
         dy_ff      <= dy_new;
         yerr_ff    <= yabs[17:0];
         neg_ff     <= neg_new;
         x_ff       <= CORDIC_K;
         y_ff       <= '0;
         z_ff       <= z_fold[19:0];
         lon_acc_ff <= '0;
         lat_acc_ff <= '0;
         dist_ff    <= '0;
      end else begin
         if (cmd.rot_en) begin
            if (!z_ff[19]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - atan_s;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + atan_s;
            end
         end
         if (pend_ff) begin
            case (pidx_ff)
               MUL_C_DX, MUL_S_DY:   lon_acc_ff <= lon_acc_ff + prod_ff;
               MUL_C_DY:             lat_acc_ff <= lat_acc_ff + prod_ff;
               MUL_S_DX:             lat_acc_ff <= lat_acc_ff - prod_ff;
               MUL_DX_DX, MUL_DY_DY: dist_ff    <= dist_ff + prod_ff;
               MUL_GSQ:              gsq_ff     <= prod_ff[39:0];
               default: ;
            endcase
         end
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
         pidx_ff <= cmd.mul_idx;
      end
      if (cmd.commit) begin
         rsp_status_ff <= r_status;
         rsp_speed_ff  <= r_speed;
         rsp_done_ff   <= r_done;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_speed_x  = rsp_speed_ff;
   assign rsp_done_res = rsp_done_ff;

endmodule

// ===== hw/rtl/straight_dock_controller_top.sv =====
// ----------------------------------------------------------------------------
// straight_dock_controller_top
// Straight docking controller: one pose sample in, one speed/status item out.
// ----------------------------------------------------------------------------
// steps from accept to result for a start or an active tick
// (16 cordic iterations, 7 multiply steps on one shared multiplier, drain, decide);
// an idle tick, a timeout, a stop or an invalid pose goes straight to decide
// throughput: one item at a time, next item accepted as soon as a result is posted
// reset: synchronous, clears docking state, restores register defaults, no clearing pass
module straight_dock_controller_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [18:0] req_target_yaw,
   input  logic signed [31:0] req_pose_x,
   input  logic signed [31:0] req_pose_y,
   input  logic signed [18:0] req_pose_yaw,
   input  logic               req_pose_valid,
   input  logic               req_stop_request,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [20:0] rsp_speed_x,
   output logic               rsp_done_res,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_wdata
);
   import sdc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sdc_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_func         (req_func),
      .req_target_x     (req_target_x),
      .req_target_y     (req_target_y),
      .req_target_yaw   (req_target_yaw),
      .req_pose_x       (req_pose_x),
      .req_pose_y       (req_pose_y),
      .req_pose_yaw     (req_pose_yaw),
      .req_pose_valid   (req_pose_valid),
      .req_stop_request (req_stop_request),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_speed_x      (rsp_speed_x),
      .rsp_done_res     (rsp_done_res)
   );

endmodule

// ===== hw/rtl/sdc_checker.sv =====
// ----------------------------------------------------------------------------
// sdc_checker
// Port-level checks on the straight dock controller.
// ----------------------------------------------------------------------------
module sdc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_status,
   input logic signed [20:0] rsp_speed_x,
   input logic               rsp_done_res
);
   import sdc_pkg::*;

   // one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while another is in flight");

   a_speed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_MOVING) |-> (rsp_speed_x == '0))
      else $error("nonzero speed with a non-moving status");

   a_done_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> (rsp_status != STS_MOVING) && (rsp_status != STS_IDLE))
      else $error("done flagged with moving or idle status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_speed_x))
      else $error("stalled result changed");

endmodule

bind straight_dock_controller_top sdc_checker u_sdc_checker (.*);
